[hw/rtl/frpd_pkg.sv]
// Shared types and constants for the fan rpm to PWM duty converter.
// No dependencies; compile before the channel interfaces and the top level.
package frpd_pkg;

  localparam int SPEED_W = 16;
  localparam int DUTY_W  = 14;
  localparam int MODE_W  = 2;
  localparam int MINDUTY_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Dividend width: full scale 100000 needs 17 bits.
  localparam int DIVD_W = 17;

  localparam logic [DIVD_W-1:0] FULL_SCALE   = DIVD_W'(100000);
  localparam logic [DIVD_W-1:0] DUTY_MAX     = DIVD_W'(10000);
  localparam logic [DIVD_W-1:0] DUTY_MID     = DIVD_W'(5000);
  localparam logic [DIVD_W-1:0] PWM_SCALE    = DIVD_W'(1000);
  localparam logic [MINDUTY_W-1:0] HALF_PCT  = MINDUTY_W'(50);
  localparam logic [6:0]        PCT_TO_HUND  = 7'd100;
  localparam logic [SPEED_W-1:0] DIV_TEN     = SPEED_W'(10);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION_MODE   = 2'd0,
    CFG_MIN_SPEED        = 2'd1,
    CFG_MAX_SPEED        = 2'd2,
    CFG_MIN_DUTY_PERCENT = 2'd3
  } cfg_idx_t;

  // Direction modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE  = 2'd0,
    MODE_GPIO    = 2'd1,
    MODE_PWM     = 2'd2,
    MODE_INVALID = 2'd3
  } dir_mode_t;

endpackage

[hw/rtl/frpd_in_if.sv]
// Request channel: one beat carries a speed request and a direction.
// Depends on frpd_pkg.
interface frpd_in_if;
  import frpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_request;
  logic               direction;

  modport source (output valid, output speed_request, output direction, input ready);
  modport sink   (input valid, input speed_request, input direction, output ready);
endinterface

[hw/rtl/frpd_out_if.sv]
// Result channel: one beat carries the duty and the applied speed/direction.
// Depends on frpd_pkg.
interface frpd_out_if;
  import frpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_hundredths;
  logic [SPEED_W-1:0] applied_speed;
  logic               held_direction;
  logic               dir_line_strobe;
  logic               dir_line_value;

  modport source (output valid, output duty_hundredths, output applied_speed,
                  output held_direction, output dir_line_strobe,
                  output dir_line_value, input ready);
  modport sink   (input valid, input duty_hundredths, input applied_speed,
                  input held_direction, input dir_line_strobe,
                  input dir_line_value, output ready);
endinterface

[hw/rtl/frpd_cfg_if.sv]
// Configuration write channel: register index plus write data per beat.
// Depends on frpd_pkg.
interface frpd_cfg_if;
  import frpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/fan_rpm_to_pwm_duty.sv]
// Fan rpm to PWM duty converter, top level with its shared restoring divider.
// Depends on frpd_pkg, frpd_in_if, frpd_out_if, frpd_cfg_if.
//
//  channel   dir   beat contents
//  in_ch     in    speed_request[15:0], direction
//  out_ch    out   duty_hundredths[13:0], applied_speed[15:0], held_direction,
//                  dir_line_strobe, dir_line_value
//  cfg_ch    in    index[1:0], data[15:0]; always ready
//
// A request runs from accept to result through two 17-step restoring divides on the
// shared divider (full scale, or pwm_pct * 1000 in PWM mode, divided by max_speed, then
// by 10) around one multiply by the clamped rpm, then a load of the duty into the output
// register. Request ready only while idle; a result waits in the output register on a
// sink stall and the next one holds until it frees. rst_n is synchronous, active low:
// register defaults, direction cleared.
module fan_rpm_to_pwm_duty (
  input  logic       clk,
  input  logic       rst_n,
  frpd_in_if.sink    in_ch,
  frpd_out_if.source out_ch,
  frpd_cfg_if.sink   cfg_ch
);
  import frpd_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVD_W - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV2 = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Configuration registers
  dir_mode_t               mode_r;
  logic [SPEED_W-1:0]      min_speed_r;
  logic [SPEED_W-1:0]      max_speed_r;
  logic [MINDUTY_W-1:0]    min_duty_r;

  // Sequencer and request state
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SPEED_W-1:0]      rpm_r, rpm_nxt;
  logic                    dir_r, dir_nxt;
  logic                    held_dir_r, held_dir_nxt;

  // Shared divider registers
  logic [DIVD_W-1:0]       quo_r, quo_nxt;
  logic [SPEED_W-1:0]      rem_r, rem_nxt;
  logic [SPEED_W-1:0]      den_r, den_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;
  logic [DUTY_W-1:0]       duty_r;
  logic [SPEED_W-1:0]      speed_out_r;
  logic                    strobe_r, line_r;

  // Datapath wires
  logic [SPEED_W-1:0]      rpm_clamp;
  logic [DIVD_W-1:0]       shifted;
  logic                    fits;
  logic [DIVD_W-1:0]       diff;
  logic [2*DIVD_W-1:0]     prod;
  logic [MINDUTY_W-1:0]    pwm_pct;
  logic [DIVD_W-1:0]       first_dividend;
  logic [SPEED_W-1:0]      first_divisor;
  logic [DIVD_W-1:0]       floor_duty;
  logic [DIVD_W-1:0]       lin_duty;
  logic [DIVD_W-1:0]       pwm_v;
  logic [DIVD_W-1:0]       duty_calc;

  // Clamp the incoming request: raise a nonzero request to min, then lower to max
  always_comb begin
    rpm_clamp = in_ch.speed_request;
    if (rpm_clamp < min_speed_r && rpm_clamp != '0) rpm_clamp = min_speed_r;
    if (rpm_clamp > max_speed_r) rpm_clamp = max_speed_r;
  end

  // First divide operands
  assign pwm_pct = (min_duty_r < HALF_PCT) ? (HALF_PCT - min_duty_r) : '0;
  assign first_dividend = (mode_r == MODE_PWM)
                        ? DIVD_W'(pwm_pct * PWM_SCALE) : FULL_SCALE;
  assign first_divisor  = (max_speed_r == '0) ? SPEED_W'(1) : max_speed_r;

  // One restoring divide step
  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  // Quotient times rpm; rpm never exceeds max_speed, so the product stays
  // at or below the full scale and fits the dividend width
  assign prod = quo_r * {{(DIVD_W-SPEED_W){1'b0}}, rpm_r};

  // Final duty from the divide-by-ten quotient
  assign floor_duty = DIVD_W'(min_duty_r) * DIVD_W'(PCT_TO_HUND);
  always_comb begin
    lin_duty = quo_r;
    if (lin_duty > DUTY_MAX) lin_duty = DUTY_MAX;
    if (lin_duty < floor_duty && lin_duty != '0) lin_duty = floor_duty;

    pwm_v = quo_r;
    if (pwm_v < floor_duty && pwm_v != '0) pwm_v = floor_duty;
    if (pwm_v > DUTY_MID) pwm_v = DUTY_MID;

    unique case (mode_r)
      MODE_SINGLE, MODE_GPIO: duty_calc = lin_duty;
      MODE_PWM:               duty_calc = dir_r ? (DUTY_MID - pwm_v) : (DUTY_MID + pwm_v);
      default:                duty_calc = floor_duty;
    endcase
  end

  // Handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rpm_nxt       = rpm_r;
    dir_nxt       = dir_r;
    held_dir_nxt  = held_dir_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          rpm_nxt   = rpm_clamp;
          dir_nxt   = in_ch.direction;
          quo_nxt   = first_dividend;
          rem_nxt   = '0;
          den_nxt   = first_divisor;
          cnt_nxt   = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1, S_DIV2: begin
        rem_nxt = fits ? diff[SPEED_W-1:0] : shifted[SPEED_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], fits};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = (state_r == S_DIV1) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        quo_nxt   = prod[DIVD_W-1:0];
        rem_nxt   = '0;
        den_nxt   = DIV_TEN;
        cnt_nxt   = '0;
        state_nxt = S_DIV2;
      end
      S_DONE: begin
        if (out_load) begin
          if (rpm_r != '0) held_dir_nxt = dir_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_dir_r  <= 1'b0;
      mode_r      <= MODE_SINGLE;
      min_speed_r <= '0;
      max_speed_r <= '1;
      min_duty_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_dir_r  <= held_dir_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.index))
          CFG_DIRECTION_MODE:   mode_r      <= dir_mode_t'(cfg_ch.data[MODE_W-1:0]);
          CFG_MIN_SPEED:        min_speed_r <= cfg_ch.data[SPEED_W-1:0];
          CFG_MAX_SPEED:        max_speed_r <= cfg_ch.data[SPEED_W-1:0];
          CFG_MIN_DUTY_PERCENT: min_duty_r  <= cfg_ch.data[MINDUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rpm_r <= rpm_nxt;
    dir_r <= dir_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (out_load) begin
      duty_r      <= duty_calc[DUTY_W-1:0];
      speed_out_r <= rpm_r;
      strobe_r    <= (mode_r == MODE_GPIO);
      line_r      <= (mode_r == MODE_GPIO) && dir_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.duty_hundredths = duty_r;
  assign out_ch.applied_speed   = speed_out_r;
  assign out_ch.held_direction  = held_dir_r;
  assign out_ch.dir_line_strobe = strobe_r;
  assign out_ch.dir_line_value  = line_r;

  // Checks
  a_accept_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_DIV1))
    else $error("accepted request did not start the divider");

  a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.duty_hundredths <= DUTY_MAX[DUTY_W-1:0]))
    else $error("duty above full scale");

  a_line_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.dir_line_strobe) |-> !out_ch.dir_line_value)
    else $error("direction line value without strobe");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.valid && state_r == S_IDLE))
    else $error("finished result not presented");

endmodule
